// File: rtl/core/ccpg_pkg.sv
// Shared constants, types and the quarter-wave sine table builder for the
// circular chirp position generator. No dependencies.
`timescale 1ns / 1ps

package ccpg_pkg;

   // Phase, table and amplitude sizing
   localparam int PHASE_BITS     = 32;
   localparam int SINE_ADDR_BITS = 10;
   localparam int SINE_AMP_BITS  = 16;

   localparam int TABLE_LEN = 1 << SINE_ADDR_BITS;
   localparam int AMP_W     = SINE_AMP_BITS - 1;

   // Field and register widths
   localparam int COUNT_W  = 16;
   localparam int STEP_W   = 32;
   localparam int RADIUS_W = 10;
   localparam int POS_W    = 15;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [POS_W-2:0] POS_MAX = 14'd16383;

   // Register reset values
   localparam logic [COUNT_W-1:0]  HOLD_SAMPLES_RST      = 16'd1500;
   localparam logic [COUNT_W-1:0]  SWEEP_SAMPLES_RST     = 16'd8192;
   localparam logic [STEP_W-1:0]   HOLD_PHASE_STEP_RST   = 32'd14316558;
   localparam logic [STEP_W-1:0]   SWEEP_FIRST_STEP_RST  = 32'd14384723;
   localparam logic [STEP_W-1:0]   SWEEP_STEP_GROWTH_RST = 32'd136332;
   localparam logic [RADIUS_W-1:0] RADIUS_RST            = 10'd200;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOLD_SAMPLES      = 3'd0,
      CSR_SWEEP_SAMPLES     = 3'd1,
      CSR_HOLD_PHASE_STEP   = 3'd2,
      CSR_SWEEP_FIRST_STEP  = 3'd3,
      CSR_SWEEP_STEP_GROWTH = 3'd4,
      CSR_RADIUS            = 3'd5
   } csr_index_type;

   typedef logic [AMP_W-1:0] sine_table_type [TABLE_LEN];

   // Quarter-wave entry k: Q30 Taylor series of sin(pi/2*(k+0.5)/TABLE_LEN)
   function automatic longint unsigned sine_entry(input longint unsigned k);
      longint unsigned half_pi_q30;
      longint unsigned q30_one;
      longint unsigned amp_max;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      half_pi_q30 = 64'd1686629713;
      q30_one     = 64'd1 << 30;
      amp_max     = (64'd1 << AMP_W) - 64'd1;
      x  = (half_pi_q30 * ((k << 1) + 64'd1)) >> (SINE_ADDR_BITS + 1);
      x2 = (x * x) >> 30;
      t  = q30_one - x2 / 110;
      t  = q30_one - ((x2 * t) >> 30) / 72;
      t  = q30_one - ((x2 * t) >> 30) / 42;
      t  = q30_one - ((x2 * t) >> 30) / 20;
      t  = q30_one - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      return (s * amp_max + (64'd1 << 29)) >> 30;
   endfunction

   // Whole table, evaluated at elaboration
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      for (int k = 0; k < TABLE_LEN; k++) begin
         tbl[k] = AMP_W'(sine_entry(longint'(k)));
      end
      return tbl;
   endfunction

endpackage

// File: rtl/core/circular_chirp_position_generator.sv
// Circular chirp position generator: hold, linear-chirp sweep, then done.
// Throughput: one item per cycle unless rsp_stall holds the pipeline; the
// segment sequencer and sine ROM read share the first stage, the radius
// multiply and clamp form the second. Synchronous active-high reset loads
// the register defaults, returns to the hold segment and zeroes the phase.
`timescale 1ns / 1ps

module circular_chirp_position_generator
   import ccpg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   // input items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_restart,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [POS_W-1:0]     rsp_x_pos,
   output logic [POS_W-1:0]     rsp_y_pos,
   output logic                 rsp_in_sweep,
   output logic                 rsp_last_sample,
   output logic                 rsp_finished
);

   typedef enum logic [2:0] {
      SEG_HOLD  = 3'b001,
      SEG_SWEEP = 3'b010,
      SEG_DONE  = 3'b100
   } segment_type;

   typedef struct packed {
      logic [1:0] quad_cos;
      logic [1:0] quad_sin;
      logic       in_sweep;
      logic       last;
      logic       done;
   } stage_flags_type;

   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, {(PHASE_BITS-2){1'b0}}};

   // Configuration registers
   logic [COUNT_W-1:0]  hold_samples_ff;
   logic [COUNT_W-1:0]  sweep_samples_ff;
   logic [STEP_W-1:0]   hold_phase_step_ff;
   logic [STEP_W-1:0]   sweep_first_step_ff;
   logic [STEP_W-1:0]   sweep_step_growth_ff;
   logic [RADIUS_W-1:0] radius_ff;

   // Sequencer state
   segment_type             segment_ff, segment_in;
   logic [PHASE_BITS-1:0]   phase_acc_ff, phase_acc_in;
   logic [PHASE_BITS-1:0]   phase_step_ff, phase_step_in;
   logic [COUNT_W-1:0]      sample_index_ff, sample_index_in;

   // Pipeline
   logic                    s1_valid_ff, s1_valid_in;
   stage_flags_type         s1_flags_ff, s1_flags_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]        x_pos_ff, x_pos_in;
   logic [POS_W-1:0]        y_pos_ff, y_pos_in;
   logic                    in_sweep_ff, last_ff, finished_ff;
   logic [POS_W-1:0]        held_x_ff, held_x_in;
   logic [POS_W-1:0]        held_y_ff, held_y_in;

   logic                    out_load;
   logic                    s1_load;
   logic                    accept;

   // Sequencer combinational terms
   segment_type             seg_a, seg_b, seg_c;
   logic [PHASE_BITS-1:0]   acc_a, acc_b;
   logic [PHASE_BITS-1:0]   step_a, step_b;
   logic [COUNT_W-1:0]      idx_a, idx_b;
   logic                    emit;
   logic                    sweeping;
   logic [PHASE_BITS-1:0]   phase_sin, phase_cos;
   logic [SINE_ADDR_BITS-1:0] addr_sin, addr_cos;

   logic [AMP_W-1:0]        mag_cos, mag_sin;
   logic [POS_W-1:0]        coord_x, coord_y;

   // Handshake: output register advances when empty or taken
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || out_load;
   assign req_stall = !s1_load;
   assign accept    = req_valid && s1_load;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_samples_ff      <= HOLD_SAMPLES_RST;
         sweep_samples_ff     <= SWEEP_SAMPLES_RST;
         hold_phase_step_ff   <= HOLD_PHASE_STEP_RST;
         sweep_first_step_ff  <= SWEEP_FIRST_STEP_RST;
         sweep_step_growth_ff <= SWEEP_STEP_GROWTH_RST;
         radius_ff            <= RADIUS_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_HOLD_SAMPLES:      hold_samples_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_SWEEP_SAMPLES:     sweep_samples_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_HOLD_PHASE_STEP:   hold_phase_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_SWEEP_FIRST_STEP:  sweep_first_step_ff  <= csr_wdata[STEP_W-1:0];
            CSR_SWEEP_STEP_GROWTH: sweep_step_growth_ff <= csr_wdata[STEP_W-1:0];
            CSR_RADIUS:            radius_ff            <= csr_wdata[RADIUS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Segment sequencer: restart, segment ends, then emit and advance
   always_comb begin
      if (req_restart) begin
         seg_a  = SEG_HOLD;
         acc_a  = '0;
         step_a = '0;
         idx_a  = '0;
      end else begin
         seg_a  = segment_ff;
         acc_a  = phase_acc_ff;
         step_a = phase_step_ff;
         idx_a  = sample_index_ff;
      end

      if (seg_a == SEG_HOLD && idx_a >= hold_samples_ff) begin
         seg_b  = SEG_SWEEP;
         acc_b  = '0;
         step_b = PHASE_BITS'(sweep_first_step_ff);
         idx_b  = '0;
      end else begin
         seg_b  = seg_a;
         acc_b  = acc_a;
         step_b = step_a;
         idx_b  = idx_a;
      end

      if (seg_b == SEG_SWEEP && idx_b >= sweep_samples_ff) begin
         seg_c = SEG_DONE;
      end else begin
         seg_c = seg_b;
      end

      emit     = (seg_c == SEG_HOLD) || (seg_c == SEG_SWEEP);
      sweeping = (seg_c == SEG_SWEEP);

      segment_in      = emit ? seg_c : SEG_DONE;
      phase_acc_in    = acc_b;
      phase_step_in   = step_b;
      sample_index_in = idx_b;
      if (emit) begin
         if (sweeping) begin
            phase_acc_in  = acc_b + step_b;
            phase_step_in = step_b + PHASE_BITS'(sweep_step_growth_ff);
         end else begin
            phase_acc_in  = acc_b + PHASE_BITS'(hold_phase_step_ff);
         end
         sample_index_in = idx_b + COUNT_W'(1);
      end

      // Table addresses, mirrored in odd quadrants
      phase_sin = acc_b;
      phase_cos = acc_b + QUARTER_TURN;
      addr_sin  = phase_sin[PHASE_BITS-3 -: SINE_ADDR_BITS];
      addr_cos  = phase_cos[PHASE_BITS-3 -: SINE_ADDR_BITS];
      if (phase_sin[PHASE_BITS-2]) begin
         addr_sin = ~addr_sin;
      end
      if (phase_cos[PHASE_BITS-2]) begin
         addr_cos = ~addr_cos;
      end

      s1_flags_in.quad_cos = phase_cos[PHASE_BITS-1 -: 2];
      s1_flags_in.quad_sin = phase_sin[PHASE_BITS-1 -: 2];
      s1_flags_in.in_sweep = sweeping;
      s1_flags_in.last     = sweeping &&
                             ({1'b0, idx_b} + 17'd1 == {1'b0, sweep_samples_ff});
      s1_flags_in.done     = !emit;
   end

   // Advance sequencer state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         segment_ff      <= SEG_HOLD;
         phase_acc_ff    <= '0;
         phase_step_ff   <= '0;
         sample_index_ff <= '0;
      end else if (accept) begin
         segment_ff      <= segment_in;
         phase_acc_ff    <= phase_acc_in;
         phase_step_ff   <= phase_step_in;
         sample_index_ff <= sample_index_in;
      end
   end

   // Stage 1: ROM read and flags
   ccpg_sine_rom u_sine_rom (
      .clock     (clock),
      .rd_en     (s1_load),
      .addr_a    (addr_cos),
      .addr_b    (addr_sin),
      .data_a_ff (mag_cos),
      .data_b_ff (mag_sin)
   );

   assign s1_valid_in = s1_load ? accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_flags_ff <= s1_flags_in;
      end
   end

   // Stage 2: scale by radius and sign
   ccpg_scale u_scale_x (
      .radius    (radius_ff),
      .magnitude (mag_cos),
      .negate    (s1_flags_ff.quad_cos[1]),
      .coord     (coord_x)
   );

   ccpg_scale u_scale_y (
      .radius    (radius_ff),
      .magnitude (mag_sin),
      .negate    (s1_flags_ff.quad_sin[1]),
      .coord     (coord_y)
   );

   // Pick held position in done, otherwise the new point and remember it
   always_comb begin
      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      if (s1_flags_ff.done) begin
         x_pos_in = held_x_ff;
         y_pos_in = held_y_ff;
      end else begin
         x_pos_in = coord_x;
         y_pos_in = coord_y;
         if (out_load && s1_valid_ff) begin
            held_x_in = coord_x;
            held_y_in = coord_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         x_pos_ff    <= x_pos_in;
         y_pos_ff    <= y_pos_in;
         in_sweep_ff <= s1_flags_ff.in_sweep;
         last_ff     <= s1_flags_ff.last;
         finished_ff <= s1_flags_ff.done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_pos       = x_pos_ff;
   assign rsp_y_pos       = y_pos_ff;
   assign rsp_in_sweep    = in_sweep_ff;
   assign rsp_last_sample = last_ff;
   assign rsp_finished    = finished_ff;

`ifndef ASSERT_OFF
   // A stall toward the source only while both stages hold items
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free pipeline stage");

   // Final sample flag only inside the sweep
   a_last_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_last_sample || rsp_in_sweep))
      else $error("last_sample outside sweep");

   // Finished results never claim sweep
   a_done_not_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_finished && rsp_in_sweep))
      else $error("finished and in_sweep together");

   // Done results repeat the held position
   a_done_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (rsp_x_pos == held_x_ff && rsp_y_pos == held_y_ff))
      else $error("done result differs from held position");
`endif

endmodule

// File: rtl/core/ccpg_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
// Depends on ccpg_pkg for the table contents and widths.
`timescale 1ns / 1ps

module ccpg_sine_rom
   import ccpg_pkg::*;
(
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [SINE_ADDR_BITS-1:0] addr_a,
   input  logic [SINE_ADDR_BITS-1:0] addr_b,
   output logic [AMP_W-1:0]          data_a_ff,
   output logic [AMP_W-1:0]          data_b_ff
);

   localparam sine_table_type SINE_ROM = build_sine_table();

   // Read both ports when enabled, hold otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

endmodule

// File: rtl/core/ccpg_scale.sv
// Scales one table magnitude by the radius into 1/16 mm, rounds, clamps
// and applies the quadrant sign. Depends on ccpg_pkg.
`timescale 1ns / 1ps

module ccpg_scale
   import ccpg_pkg::*;
(
   input  logic [RADIUS_W-1:0] radius,
   input  logic [AMP_W-1:0]    magnitude,
   input  logic                negate,
   output logic [POS_W-1:0]    coord
);

   localparam int PROD_W = RADIUS_W + 4 + AMP_W + 1;
   localparam int MAG_W  = PROD_W - AMP_W;
   localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (AMP_W - 1);

   logic [PROD_W-1:0] prod_sum;
   logic [MAG_W-1:0]  mag_full;
   logic [POS_W-2:0]  mag_clamp;

   // Multiply radius*16 by the table value and round
   assign prod_sum = PROD_W'({radius, 4'b0000}) * PROD_W'(magnitude) + ROUND;
   assign mag_full = prod_sum[PROD_W-1:AMP_W];

   // Clamp to the positive range, then give the sign
   always_comb begin
      if (mag_full > MAG_W'(POS_MAX)) begin
         mag_clamp = POS_MAX;
      end else begin
         mag_clamp = mag_full[POS_W-2:0];
      end
      if (negate) begin
         coord = POS_W'(-{1'b0, mag_clamp});
      end else begin
         coord = {1'b0, mag_clamp};
      end
   end

endmodule
